### design/psm_pkg.sv
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types and constants for the packet sequence timing monitor.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int unsigned SeqW    = 32;
  localparam int unsigned TimeW   = 63;
  localparam int unsigned CountW  = 64;
  localparam int unsigned PeriodW = 40;
  localparam int unsigned DataW   = 64;
  localparam int unsigned AddrW   = 4;

  localparam logic [PeriodW-1:0] PeriodReset = 40'd10000000000;

  // register index within the APB map (one 64-bit register per 8 bytes)
  localparam logic RegWindowPeriod = 1'b0;

  // one result beat
  typedef struct packed {
    logic [CountW-1:0]        item_count;
    logic [CountW-1:0]        gap_total;
    logic [CountW-1:0]        duplicate_count;
    logic [CountW-1:0]        reset_count;
    logic [CountW-1:0]        backward_count;
    logic [TimeW-1:0]         max_interval;
    logic [CountW-1:0]        min_interval;
    logic                     window_done;
    logic [TimeW-1:0]         window_host_delta;
    logic signed [CountW-1:0] window_sensor_delta;
  } psm_result_t;

endpackage

### design/psm_core.sv
// ----------------------------------------------------------------------------
// psm_core
// Running statistics state and its update for one arrival.
// ----------------------------------------------------------------------------
module psm_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [psm_pkg::SeqW-1:0]     seq_id,
  input  logic [psm_pkg::TimeW-1:0]    sensor_time_ns,
  input  logic [psm_pkg::TimeW-1:0]    host_time_ns,
  input  logic [psm_pkg::PeriodW-1:0]  window_period_ns,
  output psm_pkg::psm_result_t         result
);
  import psm_pkg::*;

  // statistics state
  logic [CountW-1:0] arrivals,       arrivals_next;
  logic [CountW-1:0] gap_sum,        gap_sum_next;
  logic [CountW-1:0] dup_total,      dup_total_next;
  logic [CountW-1:0] reset_total,    reset_total_next;
  logic [CountW-1:0] backward_total, backward_total_next;
  logic [SeqW-1:0]   prev_seq;
  logic [TimeW-1:0]  prev_sensor_time;
  logic [TimeW-1:0]  prev_host_time;
  logic [TimeW-1:0]  largest_interval,  largest_interval_next;
  logic [CountW-1:0] smallest_interval, smallest_interval_next;
  logic [TimeW-1:0]  window_host_start,   window_host_start_next;
  logic [TimeW-1:0]  window_sensor_start, window_sensor_start_next;

  logic              first;
  logic [TimeW:0]    host_dt;
  logic [SeqW-1:0]   seq_d;
  logic [TimeW:0]    win_host_diff;
  logic [TimeW-1:0]  win_start_h;
  logic [TimeW-1:0]  win_start_s;
  logic              win_close;
  psm_result_t       result_next;

  // first arrival (arrivals at zero) only seeds the window and history
  assign first   = (arrivals == '0);
  assign host_dt = {1'b0, host_time_ns} - {1'b0, prev_host_time};
  assign seq_d   = seq_id - prev_seq;

  always_comb begin
    gap_sum_next           = gap_sum;
    dup_total_next         = dup_total;
    reset_total_next       = reset_total;
    backward_total_next    = backward_total;
    largest_interval_next  = largest_interval;
    smallest_interval_next = smallest_interval;
    if (!first) begin
      // positive host interval updates the extremes
      if (!host_dt[TimeW] && (host_dt[TimeW-1:0] != '0)) begin
        if (host_dt[TimeW-1:0] > largest_interval)
          largest_interval_next = host_dt[TimeW-1:0];
        if ({1'b0, host_dt[TimeW-1:0]} < smallest_interval)
          smallest_interval_next = {1'b0, host_dt[TimeW-1:0]};
      end
      // sensor time that did not advance
      if (sensor_time_ns <= prev_sensor_time)
        backward_total_next = backward_total + 1'b1;
      // serial-number classification of the sequence delta
      if (seq_d == '0)
        dup_total_next = dup_total + 1'b1;
      else if (!seq_d[SeqW-1])
        gap_sum_next = gap_sum + {{(CountW-SeqW){1'b0}}, seq_d - 1'b1};
      else
        reset_total_next = reset_total + 1'b1;
    end
  end

  // window test against the start that applies to this arrival
  assign win_start_h   = first ? host_time_ns   : window_host_start;
  assign win_start_s   = first ? sensor_time_ns : window_sensor_start;
  assign win_host_diff = {1'b0, host_time_ns} - {1'b0, win_start_h};
  assign win_close     = !win_host_diff[TimeW] &&
                         (win_host_diff[TimeW-1:0] >=
                          {{(TimeW-PeriodW){1'b0}}, window_period_ns});
  assign window_host_start_next   = win_close ? host_time_ns   : win_start_h;
  assign window_sensor_start_next = win_close ? sensor_time_ns : win_start_s;
  assign arrivals_next = arrivals + 1'b1;

  always_comb begin
    result_next.item_count          = arrivals_next;
    result_next.gap_total           = gap_sum_next;
    result_next.duplicate_count     = dup_total_next;
    result_next.reset_count         = reset_total_next;
    result_next.backward_count      = backward_total_next;
    result_next.max_interval        = largest_interval_next;
    result_next.min_interval        = smallest_interval_next;
    result_next.window_done         = win_close;
    result_next.window_host_delta   = win_close ? win_host_diff[TimeW-1:0] : '0;
    result_next.window_sensor_delta = win_close ?
        signed'({1'b0, sensor_time_ns} - {1'b0, win_start_s}) : '0;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      arrivals            <= '0;
      gap_sum             <= '0;
      dup_total           <= '0;
      reset_total         <= '0;
      backward_total      <= '0;
      prev_seq            <= '0;
      prev_sensor_time    <= '0;
      prev_host_time      <= '0;
      largest_interval    <= '0;
      smallest_interval   <= '1;
      window_host_start   <= '0;
      window_sensor_start <= '0;
    end else if (step) begin
      arrivals            <= arrivals_next;
      gap_sum             <= gap_sum_next;
      dup_total           <= dup_total_next;
      reset_total         <= reset_total_next;
      backward_total      <= backward_total_next;
      prev_seq            <= seq_id;
      prev_sensor_time    <= sensor_time_ns;
      prev_host_time      <= host_time_ns;
      largest_interval    <= largest_interval_next;
      smallest_interval   <= smallest_interval_next;
      window_host_start   <= window_host_start_next;
      window_sensor_start <= window_sensor_start_next;
    end
  end

  // result register (payload, no reset)
  always_ff @(posedge clk) begin
    if (step) result <= result_next;
  end

endmodule

### design/packet_sequence_timing_monitor_top.sv
// ----------------------------------------------------------------------------
// packet_sequence_timing_monitor_top
// Sequence gap, duplicate and timing statistics over a packet arrival stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one arrival per beat:
//   seq_id, sensor_time_ns, host_time_ns. Output channel (out_valid/out_ready)
//   returns one result beat per arrival with the running counters, interval
//   extremes and the drift window report.
//   The APB port holds window_period_ns at byte address 0 (64-bit data).
//   Write it only while no arrival is in flight.
// Path: an accepted arrival passes through the input register, then the
//   statistics update into the result register; the input register holds
//   it while the result register is stalled.
// Throughput: one arrival per cycle while results are taken; the statistics
//   update for one arrival is registered, so the next arrival sees the new state.
// Stall: while out_ready is low the result register holds; the input
//   register still takes one more beat if it is empty, then in_ready drops
//   until the result is taken.
// Reset: rst clears all counters and history, sets the smallest interval
//   to all ones and the window period to 10 s; both channels come up empty.
// ----------------------------------------------------------------------------
module packet_sequence_timing_monitor_top (
  input  logic                                clk,
  input  logic                                rst,
  // APB configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [psm_pkg::AddrW-1:0]           paddr,
  input  logic [psm_pkg::DataW-1:0]           pwdata,
  output logic [psm_pkg::DataW-1:0]           prdata,
  output logic                                pready,
  // arrival channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [psm_pkg::SeqW-1:0]            seq_id,
  input  logic [psm_pkg::TimeW-1:0]           sensor_time_ns,
  input  logic [psm_pkg::TimeW-1:0]           host_time_ns,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [psm_pkg::CountW-1:0]          item_count,
  output logic [psm_pkg::CountW-1:0]          gap_total,
  output logic [psm_pkg::CountW-1:0]          duplicate_count,
  output logic [psm_pkg::CountW-1:0]          reset_count,
  output logic [psm_pkg::CountW-1:0]          backward_count,
  output logic [psm_pkg::TimeW-1:0]           max_interval,
  output logic [psm_pkg::CountW-1:0]          min_interval,
  output logic                                window_done,
  output logic [psm_pkg::TimeW-1:0]           window_host_delta,
  output logic signed [psm_pkg::CountW-1:0]   window_sensor_delta
);
  import psm_pkg::*;

  logic [PeriodW-1:0] window_period_ns;
  logic               cfg_write;
  logic               reg_sel;

  logic               s1_valid;
  logic [SeqW-1:0]    s1_seq;
  logic [TimeW-1:0]   s1_sensor;
  logic [TimeW-1:0]   s1_host;
  logic               advance;
  psm_result_t        result;

  // configuration register
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[AddrW-1] == RegWindowPeriod);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_period_ns <= PeriodReset;
    end else if (cfg_write && reg_sel) begin
      window_period_ns <= pwdata[PeriodW-1:0];
    end
  end

  assign prdata = reg_sel ? {{(DataW-PeriodW){1'b0}}, window_period_ns} : '0;

  // input register: moves on whenever the result register is free
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_seq    <= seq_id;
      s1_sensor <= sensor_time_ns;
      s1_host   <= host_time_ns;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  psm_core u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .seq_id           (s1_seq),
    .sensor_time_ns   (s1_sensor),
    .host_time_ns     (s1_host),
    .window_period_ns (window_period_ns),
    .result           (result)
  );

  assign item_count          = result.item_count;
  assign gap_total           = result.gap_total;
  assign duplicate_count     = result.duplicate_count;
  assign reset_count         = result.reset_count;
  assign backward_count      = result.backward_count;
  assign max_interval        = result.max_interval;
  assign min_interval        = result.min_interval;
  assign window_done         = result.window_done;
  assign window_host_delta   = result.window_host_delta;
  assign window_sensor_delta = result.window_sensor_delta;

  // checks
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled result");

  a_window_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !window_done) |->
      (window_host_delta == '0 && window_sensor_delta == '0))
    else $error("window deltas nonzero without a closed window");

  a_interval_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && min_interval != '1) |->
      ({1'b0, max_interval} >= min_interval && max_interval != '0))
    else $error("interval extremes out of order");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(item_count)))
    else $error("result changed while stalled");

endmodule
